>>> design/imrc_pkg.sv
// ----------------------------------------------------------------------------
// imrc_pkg
// shared types and constants of the integer matrix row/column engine
// ----------------------------------------------------------------------------
package imrc_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int IDX_BITS   = 7;
    localparam int CFG_BITS   = 31;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;
    localparam logic [1:0] ST_BIG     = 2'd3;

    localparam logic [3:0] REQ_GET      = 4'd0;
    localparam logic [3:0] REQ_SET      = 4'd1;
    localparam logic [3:0] REQ_REMOVE   = 4'd2;
    localparam logic [3:0] REQ_ERASE_R  = 4'd3;
    localparam logic [3:0] REQ_ERASE_C  = 4'd4;
    localparam logic [3:0] REQ_ADD_R    = 4'd5;
    localparam logic [3:0] REQ_ADD_C    = 4'd6;
    localparam logic [3:0] REQ_UNIT_R   = 4'd7;
    localparam logic [3:0] REQ_UNIT_C   = 4'd8;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [VALUE_BITS-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
    } clr_req_t;

endpackage

>>> design/imrc_store.sv
// ----------------------------------------------------------------------------
// imrc_store
// matrix entry memory, zero filled by a clearing pass over all 4096 entries after reset
// ----------------------------------------------------------------------------
module imrc_store
    import imrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mem_req_t              req,
    output logic                  clearing,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] raw_reg;
    logic [ADDR_BITS-1:0]  clr_addr_reg;
    logic                  clr_busy_reg;
    clr_req_t              clr;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    // clearing pass owns the write port until every entry is zero
    assign clr.wr_en   = clr_busy_reg;
    assign clr.wr_addr = clr_addr_reg;
    assign wr_en       = clr.wr_en || req.wr_en;
    assign wr_addr     = clr.wr_en ? clr.wr_addr : req.wr_addr;
    assign wr_data     = clr.wr_en ? '0 : req.wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            raw_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_BITS'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clearing = clr_busy_reg;
    assign rd_data  = raw_reg;

endmodule

>>> design/imrc_ctrl.sv
// ----------------------------------------------------------------------------
// imrc_ctrl
// request sequencer: checks, line walks and read-modify-write of entries
// ----------------------------------------------------------------------------
module imrc_ctrl
    import imrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            req_type,
    input  logic [IDX_BITS-1:0]   index_a,
    input  logic [IDX_BITS-1:0]   index_b,
    input  logic signed [31:0]    entry_value,
    input  logic signed [31:0]    scale,
    input  logic                  mark_deleted,
    input  logic [IDX_BITS-1:0]   rows_cfg,
    input  logic [IDX_BITS-1:0]   cols_cfg,
    input  logic [CFG_BITS-1:0]   limit_cfg,
    input  logic                  mem_clearing,
    output mem_req_t              mreq,
    input  logic [VALUE_BITS-1:0] rd_data,
    output logic                  done,
    output logic [1:0]            status,
    output logic signed [31:0]    result_value,
    output logic [IDX_BITS-1:0]   result_index
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_SRC   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_CHK   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]            op_reg;
    logic [IDX_BITS-1:0]   a_reg, b_reg;
    logic signed [31:0]    val_reg, scl_reg;
    logic                  mark_reg;
    logic [IDX_BITS-1:0]   k_reg, len_reg;
    logic [1:0]            st_reg;
    logic signed [31:0]    rv_reg;
    logic [IDX_BITS-1:0]   ri_reg;
    logic [31:0]           max_reg;
    logic signed [31:0]    src_reg;
    logic signed [63:0]    prod_reg;
    logic [MAX_ROWS-1:0]   rdel_reg;
    logic [MAX_COLS-1:0]   cdel_reg;

    logic [IDX_BITS-1:0] nr, nc;
    logic [31:0]         lim;
    logic                by_col;
    logic                is_add, is_unit, is_erase, is_single;

    assign nr  = (rows_cfg > IDX_BITS'(MAX_ROWS)) ? IDX_BITS'(MAX_ROWS) : rows_cfg;
    assign nc  = (cols_cfg > IDX_BITS'(MAX_COLS)) ? IDX_BITS'(MAX_COLS) : cols_cfg;
    assign lim = {1'b0, limit_cfg};

    assign by_col    = (op_reg == REQ_ERASE_C) || (op_reg == REQ_ADD_C)
                       || (op_reg == REQ_UNIT_C);
    assign is_add    = (op_reg == REQ_ADD_R) || (op_reg == REQ_ADD_C);
    assign is_unit   = (op_reg == REQ_UNIT_R) || (op_reg == REQ_UNIT_C);
    assign is_erase  = (op_reg == REQ_ERASE_R) || (op_reg == REQ_ERASE_C);
    assign is_single = (op_reg == REQ_GET) || (op_reg == REQ_SET)
                       || (op_reg == REQ_REMOVE);

    function automatic logic [ADDR_BITS-1:0] addr_of(input logic [IDX_BITS-1:0] r,
                                                    input logic [IDX_BITS-1:0] c);
        logic [IDX_BITS-1:0] r0, c0;
        r0 = r - 1'b1;
        c0 = c - 1'b1;
        return {r0[ROW_BITS-1:0], c0[COL_BITS-1:0]};
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // line cell addresses
    logic [ADDR_BITS-1:0] a_line, b_line;
    assign a_line = by_col ? addr_of(k_reg, a_reg) : addr_of(a_reg, k_reg);
    assign b_line = by_col ? addr_of(k_reg, b_reg) : addr_of(b_reg, k_reg);

    logic signed [63:0] sum;
    logic [63:0]        sum_mag;
    assign sum     = 64'(signed'(rd_data)) + prod_reg;
    assign sum_mag = mag64(sum);

    logic in_a_r, in_b_c, in_a_n, in_b_n, del_a, del_b;
    logic [IDX_BITS-1:0] n_sel;
    logic [IDX_BITS-1:0] a0, b0;
    assign a0     = a_reg - 1'b1;
    assign b0     = b_reg - 1'b1;
    assign n_sel  = by_col ? nc : nr;
    assign in_a_r = (a_reg != '0) && (a_reg <= nr);
    assign in_b_c = (b_reg != '0) && (b_reg <= nc);
    assign in_a_n = (a_reg != '0) && (a_reg <= n_sel);
    assign in_b_n = (b_reg != '0) && (b_reg <= n_sel);
    assign del_a  = by_col ? cdel_reg[a0[COL_BITS-1:0]] : rdel_reg[a0[ROW_BITS-1:0]];
    assign del_b  = by_col ? cdel_reg[b0[COL_BITS-1:0]] : rdel_reg[b0[ROW_BITS-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rdel_reg  <= '0;
            cdel_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // mark once the erase walk has finished
            if ((state_reg == S_RD) && (k_reg > len_reg) && is_erase && mark_reg)
            begin
                if (by_col)
                begin
                    cdel_reg[a0[COL_BITS-1:0]] <= 1'b1;
                end
                else
                begin
                    rdel_reg[a0[ROW_BITS-1:0]] <= 1'b1;
                end
            end
        end
    end

    // payload and sequencing
    logic [1:0] chk_st;
    always_comb
    begin
        chk_st = ST_OK;
        if (is_single)
        begin
            if (!in_a_r || !in_b_c)
            begin
                chk_st = ST_RANGE;
            end
            else if (op_reg == REQ_GET)
            begin
                chk_st = ST_OK;
            end
            else if ((op_reg == REQ_SET) && (mag32(val_reg) > lim))
            begin
                chk_st = ST_BIG;
            end
            else if (rdel_reg[a0[ROW_BITS-1:0]] || cdel_reg[b0[COL_BITS-1:0]])
            begin
                chk_st = ST_DELETED;
            end
        end
        else if (is_add)
        begin
            if (!in_a_n || !in_b_n)
            begin
                chk_st = ST_RANGE;
            end
            else if (del_a || del_b)
            begin
                chk_st = ST_DELETED;
            end
        end
        else if (is_unit || is_erase)
        begin
            if (!in_a_n)
            begin
                chk_st = ST_RANGE;
            end
            else if (del_a)
            begin
                chk_st = ST_DELETED;
            end
        end
    end

    // state S_IDLE holds the request in a registered "pending" flag
    logic pend_reg;
    logic take;

    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= take;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mreq       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pend_reg)
                begin
                    if (chk_st != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else if (is_single)
                    begin
                        if (op_reg == REQ_SET)
                        begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = addr_of(a_reg, b_reg);
                            mreq.wr_data = val_reg;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = addr_of(a_reg, b_reg);
                            state_next   = S_WAIT;
                        end
                    end
                    else if (is_erase || is_unit || is_add)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                if (k_reg > len_reg)
                begin
                    state_next = S_DONE;
                end
                else if (is_erase)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = a_line;
                    mreq.wr_data = '0;
                end
                else if (is_unit)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = a_line;
                    state_next   = S_CHK;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = b_line;
                    state_next   = S_SRC;
                end
            end
            S_SRC:
            begin
                if (rd_data == '0)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = a_line;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (is_unit)
                begin
                    state_next = (mag32(signed'(rd_data)) == 32'd1) ? S_DONE : S_RD;
                end
                else if (sum_mag > 64'(lim))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = a_line;
                    mreq.wr_data = sum[31:0];
                    state_next   = S_RD;
                end
            end
            S_WAIT:
            begin
                if (op_reg == REQ_REMOVE)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = addr_of(a_reg, b_reg);
                    mreq.wr_data = '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sum is read in S_CHK, which follows S_MUL after the target read in S_SRC, so the
    // product registered in S_MUL is ready; rd_data in S_CHK is the target entry
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= req_type;
            a_reg    <= index_a;
            b_reg    <= index_b;
            val_reg  <= entry_value;
            scl_reg  <= scale;
            mark_reg <= mark_deleted;
            rv_reg   <= '0;
            ri_reg   <= '0;
            max_reg  <= '0;
            k_reg    <= IDX_BITS'(1);
        end
        if (pend_reg && (state_reg == S_IDLE))
        begin
            st_reg  <= chk_st;
            len_reg <= by_col ? nr : nc;
        end
        unique case (state_reg)
            S_RD:
            begin
                if ((k_reg <= len_reg) && is_erase)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_SRC:
            begin
                src_reg <= signed'(rd_data);
                if (rd_data == '0)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                prod_reg <= 64'(scl_reg) * 64'(src_reg);
            end
            S_CHK:
            begin
                if (is_unit)
                begin
                    if (mag32(signed'(rd_data)) == 32'd1)
                    begin
                        rv_reg <= signed'(rd_data);
                        ri_reg <= k_reg;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                else if (sum_mag > 64'(lim))
                begin
                    st_reg <= ST_BIG;
                end
                else
                begin
                    if (sum_mag > 64'(max_reg))
                    begin
                        max_reg <= sum_mag[31:0];
                    end
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                rv_reg <= signed'(rd_data);
            end
            default:
            begin
            end
        endcase
    end

    assign busy = mem_clearing || (state_reg != S_IDLE) || pend_reg;
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        status       = st_reg;
        result_value = '0;
        result_index = '0;
        if (st_reg == ST_OK)
        begin
            result_value = is_add ? signed'(max_reg) : rv_reg;
            result_index = ri_reg;
        end
    end

endmodule

>>> design/int_matrix_row_column_ops_core.sv
// ----------------------------------------------------------------------------
// int_matrix_row_column_ops_core
// integer matrix with entry access and elementary row/column operations
// ----------------------------------------------------------------------------
// line requests (erase, unit search, add) walk the line entry by entry through the
// store's memory request port; set, get, remove and rejected requests touch at most one entry
// throughput: one request at a time, busy high through the result strobe cycle
// reset: clearing pass zeroes the matrix with busy high, deleted marks
// clear, registers to full size
module int_matrix_row_column_ops_core
    import imrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic [3:0]          req_type,
    input  logic [IDX_BITS-1:0] index_a,
    input  logic [IDX_BITS-1:0] index_b,
    input  logic signed [31:0]  entry_value,
    input  logic signed [31:0]  scale,
    input  logic                mark_deleted,
    output logic                done,
    output logic [1:0]          status,
    output logic signed [31:0]  result_value,
    output logic [IDX_BITS-1:0] result_index
);

    logic [IDX_BITS-1:0]   rows_reg, cols_reg;
    logic [CFG_BITS-1:0]   limit_reg;
    mem_req_t              mreq;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  mem_clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= IDX_BITS'(64);
            cols_reg  <= IDX_BITS'(64);
            limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS:  rows_reg  <= cfg_data[IDX_BITS-1:0];
                CFG_COLS:  cols_reg  <= cfg_data[IDX_BITS-1:0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    imrc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .index_a      (index_a),
        .index_b      (index_b),
        .entry_value  (entry_value),
        .scale        (scale),
        .mark_deleted (mark_deleted),
        .rows_cfg     (rows_reg),
        .cols_cfg     (cols_reg),
        .limit_cfg    (limit_reg),
        .mem_clearing (mem_clearing),
        .mreq         (mreq),
        .rd_data      (rd_data),
        .done         (done),
        .status       (status),
        .result_value (result_value),
        .result_index (result_index)
    );

    imrc_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mreq),
        .clearing (mem_clearing),
        .rd_data  (rd_data)
    );

endmodule

>>> design/imrc_checker.sv
// ----------------------------------------------------------------------------
// imrc_checker
// port-level checks of the request/result sequencing
// ----------------------------------------------------------------------------
module imrc_checker
    import imrc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [1:0]          status,
    input logic signed [31:0]  result_value,
    input logic [IDX_BITS-1:0] result_index
);

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request not followed by busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((result_value == 0) && (result_index == 0)))
        else $error("error result with nonzero fields");

endmodule

bind int_matrix_row_column_ops_core imrc_checker u_imrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_value (result_value),
    .result_index (result_index)
);
